// ----- hw/rtl/fdtp_pkg.sv -----
// fdtp_pkg: shared constants, op codes, sequencer states and ring structs
// for the frame display time pacer; used by every module of the block
`timescale 1ns / 1ps
package fdtp_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);

  // shared divider: 64-bit dividend, 30-bit divisor, one bit per cycle
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  // shared multiplier: 64-bit multiplicand, 30-bit multiplier, one bit per cycle
  localparam int MUL_STEPS = 30;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  localparam logic [2:0] OP_PREDICT   = 3'd0;
  localparam logic [2:0] OP_WOKE      = 3'd1;
  localparam logic [2:0] OP_BEGIN     = 3'd2;
  localparam logic [2:0] OP_DELIVERED = 3'd3;
  localparam logic [2:0] OP_DISCARDED = 3'd4;
  localparam logic [2:0] OP_GPU_DONE  = 3'd5;
  localparam logic [2:0] OP_INFO      = 3'd6;

  localparam logic [0:0]  REG_MARGIN = 1'd0;
  localparam logic [0:0]  REG_GAIN   = 1'd1;
  localparam logic [22:0] MARGIN_RESET = 23'd1500000;
  localparam logic [16:0] GAIN_RESET   = 17'd6554;
  localparam logic [16:0] GAIN_MAX     = 17'd65536;
  localparam logic [29:0] PERIOD_RESET = 30'd10000000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PR_SETUP,
    S_PR_DIV1_GO,
    S_PR_DIV1_WAIT,
    S_PR_MUL1_GO,
    S_PR_MUL1_WAIT,
    S_PR_CHK,
    S_PR_DIV2_GO,
    S_PR_DIV2_WAIT,
    S_PR_MUL2_GO,
    S_PR_MUL2_WAIT,
    S_PR_FIN,
    S_MK_RD,
    S_EW_SETUP,
    S_EW_MUL_GO,
    S_EW_MUL_WAIT,
    S_EW_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             tag_en;
    logic             wake_en;
    logic             del_en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      tag;
    logic [63:0]      wake;
    logic [63:0]      del;
  } ring_wr_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [63:0] wake;
    logic [63:0] del;
  } ring_rd_t;

endpackage

// ----- hw/rtl/fdtp_div.sv -----
// fdtp_div: shared restoring divider, one quotient bit per cycle
// depends on fdtp_pkg for step counts
`timescale 1ns / 1ps
module fdtp_div import fdtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [29:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [29:0] remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [63:0]          quo;
  logic [29:0]          rem;
  logic [29:0]          dsr;
  logic [30:0]          trial;
  logic [30:0]          diff;
  logic                 ge;

  // one trial subtraction per cycle
  assign trial = {rem, quo[63]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[29:0] : trial[29:0];
      quo <= {quo[62:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- hw/rtl/fdtp_mul.sv -----
// fdtp_mul: shared shift-add multiplier, one multiplier bit per cycle,
// product kept modulo 2^64; depends on fdtp_pkg for step counts
`timescale 1ns / 1ps
module fdtp_mul import fdtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] mcand,
  input  logic [29:0] mplier,
  output logic        done,
  output logic [63:0] product
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [63:0]          a;
  logic [29:0]          b;
  logic [63:0]          acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // accumulate one partial product per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a   <= mcand;
      b   <= mplier;
      acc <= '0;
    end else if (busy) begin
      if (b[0]) begin
        acc <= acc + a;
      end
      a <= {a[62:0], 1'b0};
      b <= {1'b0, b[29:1]};
    end
  end

  assign product = acc;

endmodule

// ----- hw/rtl/fdtp_ring.sv -----
// fdtp_ring: frame ring of tags, wake times and delivered times
// depends on fdtp_pkg for depth and ring structs
`timescale 1ns / 1ps
module fdtp_ring import fdtp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_idx,
  input  ring_wr_t         wr,
  output ring_rd_t         rd
);

  logic [31:0] tags  [RING_DEPTH];
  logic [63:0] wakes [RING_DEPTH];
  logic [63:0] dels  [RING_DEPTH];

  // entry writes, reset clears every entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        tags[i]  <= '0;
        wakes[i] <= '0;
        dels[i]  <= '0;
      end
    end else begin
      if (wr.tag_en) begin
        tags[wr.idx] <= wr.tag;
      end
      if (wr.wake_en) begin
        wakes[wr.idx] <= wr.wake;
      end
      if (wr.del_en) begin
        dels[wr.idx] <= wr.del;
      end
    end
  end

  // single read port
  assign rd.tag  = tags[rd_idx];
  assign rd.wake = wakes[rd_idx];
  assign rd.del  = dels[rd_idx];

endmodule

// ----- hw/rtl/frame_display_time_pacer_top.sv -----
// frame_display_time_pacer_top: sequencer, state registers and config port
// depends on fdtp_pkg, fdtp_div, fdtp_mul and fdtp_ring
//
// channel  | handshake              | contents
// ---------+------------------------+----------------------------------------
// in       | in_valid / in_ready    | op, mark id, time_ns, compositor info
// out      | out_valid / out_ready  | prediction, wake, target, app time
// config   | psel / penable / pready| margin_ns at 0x0, ewma_gain at 0x4
//
// a predict transaction makes two passes through the bit-serial divider and two
// through the bit-serial multiplier; one pass through each when the target
// needs no stepping forward
// mark transactions use the ring slot given by the low bits of the id, a gpu-done
// with averaging also the multiplier; info and unknown ops go straight to the end
// in_ready is low while a transaction is in work; a held result stalls the end
// reset is synchronous and restores control state, config and the ring, not working or output registers
`timescale 1ns / 1ps
module frame_display_time_pacer_top import fdtp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [31:0]        mark_id,
  input  logic [61:0]        time_ns,
  input  logic [61:0]        comp_display_time,
  input  logic [29:0]        comp_period,
  input  logic signed [31:0] comp_extra,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_prediction,
  output logic [31:0]        new_frame_id,
  output logic signed [62:0] wake_time,
  output logic [61:0]        target_display,
  output logic [29:0]        display_period,
  output logic [31:0]        app_time,
  output logic               matched,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_t state, state_next;

  logic [22:0]      margin_ns;
  logic [16:0]      ewma_gain;
  logic [31:0]      frame_counter;
  logic [IDX_W-1:0] slot;
  logic [63:0]      last_display, comp_display, comp_time, cpu_avg, gpu_avg;
  logic [29:0]      period;

  logic [2:0]       op_r;
  logic [31:0]      fid_r;
  logic [63:0]      tm64;
  logic [63:0]      sum, ready, t, opa, sc, sg, lowprod, ew_prod;
  logic [29:0]      opb;
  logic             neg_r, limited, which, zero_r;
  logic [IDX_W-1:0] idx_r;

  logic             res_pred, res_match;
  logic [31:0]      res_id;
  logic [62:0]      res_wake;
  logic [61:0]      res_tgt;
  logic [29:0]      res_per;

  logic             div_start, div_done, mul_start, mul_done;
  logic [63:0]      div_quo, mul_prod;
  logic [29:0]      div_rem;
  ring_wr_t         wr;
  ring_rd_t         rd;

  logic             accept, cfg_wr, match;
  logic [63:0]      p64, pr_n, t_plus_p, wake_calc, lim64, dc, dg;
  logic [63:0]      ew_a, ew_s, ew_d, ew_mag, ew_new;
  logic [32:0]      lp;
  logic [16:0]      gain_eff;
  logic [31:0]      lim;
  logic signed [63:0] app_max;
  logic [31:0]      app_calc;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      margin_ns <= MARGIN_RESET;
      ewma_gain <= GAIN_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MARGIN) begin
        margin_ns <= pwdata[22:0];
      end else begin
        ewma_gain <= pwdata[16:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_GAIN) ? {15'd0, ewma_gain} : {9'd0, margin_ns};

  // shared units and ring
  fdtp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(opa), .divisor(opb),
    .done(div_done), .quotient(div_quo), .remainder(div_rem)
  );

  fdtp_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .mcand(opa), .mplier(opb),
    .done(mul_done), .product(mul_prod)
  );

  fdtp_ring u_ring (
    .clk(clk), .rst(rst), .rd_idx(idx_r), .wr(wr), .rd(rd)
  );

  // arithmetic around the sequencer
  assign p64       = {34'd0, period};
  assign pr_n      = {35'd0, period[29:1]} + last_display + p64 - comp_display;
  assign t_plus_p  = t + p64;
  assign wake_calc = t - (sum + {41'd0, margin_ns});
  assign lim       = 32'({2'd0, period} * 32'd3);
  assign lim64     = {32'd0, lim};
  assign dc        = rd.del - rd.wake;
  assign dg        = tm64 - rd.del;
  assign match     = (rd.tag == fid_r);
  assign gain_eff  = (ewma_gain > GAIN_MAX) ? GAIN_MAX : ewma_gain;
  assign ew_a      = which ? gpu_avg : cpu_avg;
  assign ew_s      = which ? sg : sc;
  assign ew_d      = ew_s - ew_a;
  assign ew_mag    = ew_d[63] ? (64'd0 - ew_d) : ew_d;
  assign lp        = {17'd0, ew_mag[15:0]} * {16'd0, gain_eff};
  assign ew_new    = zero_r ? ew_s : (neg_r ? ew_a - ew_prod : ew_a + ew_prod);

  // app time: larger average, floored at zero and clamped to 32 bits
  always_comb begin
    app_max = ($signed(cpu_avg) > $signed(gpu_avg)) ? $signed(cpu_avg) : $signed(gpu_avg);
    if (app_max < 0) begin
      app_calc = '0;
    end else if (app_max > $signed({32'd0, 32'hFFFF_FFFF})) begin
      app_calc = 32'hFFFF_FFFF;
    end else begin
      app_calc = app_max[31:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_PREDICT) begin
            state_next = S_PR_SETUP;
          end else if (op >= OP_WOKE && op <= OP_GPU_DONE) begin
            state_next = S_MK_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_PR_SETUP:     state_next = S_PR_DIV1_GO;
      S_PR_DIV1_GO:   state_next = S_PR_DIV1_WAIT;
      S_PR_DIV1_WAIT: if (div_done) state_next = S_PR_MUL1_GO;
      S_PR_MUL1_GO:   state_next = S_PR_MUL1_WAIT;
      S_PR_MUL1_WAIT: if (mul_done) state_next = S_PR_CHK;
      S_PR_CHK: begin
        state_next = ($signed(t) < $signed(ready)) ? S_PR_DIV2_GO : S_PR_FIN;
      end
      S_PR_DIV2_GO:   state_next = S_PR_DIV2_WAIT;
      S_PR_DIV2_WAIT: if (div_done) state_next = S_PR_MUL2_GO;
      S_PR_MUL2_GO:   state_next = S_PR_MUL2_WAIT;
      S_PR_MUL2_WAIT: if (mul_done) state_next = S_PR_FIN;
      S_PR_FIN:       state_next = S_DONE;
      S_MK_RD: begin
        if (match && op_r == OP_GPU_DONE && rd.wake != 64'd0 && rd.del != 64'd0) begin
          state_next = S_EW_SETUP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_EW_SETUP:    state_next = (ew_a == 64'd0) ? S_EW_UPD : S_EW_MUL_GO;
      S_EW_MUL_GO:   state_next = S_EW_MUL_WAIT;
      S_EW_MUL_WAIT: if (mul_done) state_next = S_EW_UPD;
      S_EW_UPD:      state_next = which ? S_DONE : S_EW_SETUP;
      S_DONE:        if (!out_valid || out_ready) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // unit starts and ring writes
  always_comb begin
    div_start  = (state == S_PR_DIV1_GO) || (state == S_PR_DIV2_GO);
    mul_start  = (state == S_PR_MUL1_GO) || (state == S_PR_MUL2_GO) ||
                 (state == S_EW_MUL_GO);
    wr         = '0;
    wr.idx     = idx_r;
    wr.wake    = tm64;
    wr.del     = tm64;
    case (state)
      S_PR_FIN: begin
        wr.tag_en  = 1'b1;
        wr.wake_en = 1'b1;
        wr.del_en  = 1'b1;
        wr.idx     = slot;
        wr.tag     = frame_counter;
        wr.wake    = '0;
        wr.del     = '0;
      end
      S_MK_RD: begin
        wr.wake_en = match && (op_r == OP_WOKE);
        wr.del_en  = match && (op_r == OP_DELIVERED || op_r == OP_DISCARDED);
      end
      default: begin
      end
    endcase
  end

  // sequencer state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      frame_counter <= '0;
      slot          <= '0;
      last_display  <= '0;
      comp_display  <= '0;
      period        <= PERIOD_RESET;
      comp_time     <= '0;
      cpu_avg       <= '0;
      gpu_avg       <= '0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // info updates the compositor state at once
      if (accept && op == OP_INFO) begin
        comp_display <= {2'd0, comp_display_time};
        period       <= (comp_period == 30'd0) ? 30'd1 : comp_period;
        comp_time    <= comp_extra[31] ? 64'd0 : {32'd0, comp_extra};
      end
      // new frame id and its ring slot
      if (state == S_PR_SETUP) begin
        frame_counter <= frame_counter + 32'd1;
        if (frame_counter == 32'hFFFF_FFFF || slot == IDX_W'(RING_DEPTH - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
      end
      if (state == S_PR_FIN) begin
        last_display <= t;
      end
      if (state == S_EW_UPD) begin
        if (which) begin
          gpu_avg <= ew_new;
        end else begin
          cpu_avg <= ew_new;
        end
      end
    end
  end

  // working registers of the transaction in progress
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_r      <= op;
          fid_r     <= mark_id;
          idx_r     <= mark_id[IDX_W-1:0];
          tm64      <= {2'd0, time_ns};
          res_pred  <= 1'b0;
          res_match <= 1'b0;
          res_id    <= '0;
          res_wake  <= '0;
          res_tgt   <= '0;
          res_per   <= '0;
        end
      end
      S_PR_SETUP: begin
        sum   <= cpu_avg + gpu_avg + comp_time;
        ready <= tm64 + cpu_avg + gpu_avg + comp_time;
        neg_r <= pr_n[63];
        opa   <= pr_n[63] ? (64'd0 - pr_n) : pr_n;
        opb   <= period;
      end
      S_PR_DIV1_WAIT: begin
        if (div_done) begin
          opa <= neg_r ? (64'd0 - div_quo) : div_quo;
        end
      end
      S_PR_MUL1_WAIT: begin
        if (mul_done) begin
          t <= comp_display + mul_prod;
        end
      end
      S_PR_CHK: begin
        limited <= ($signed(cpu_avg) > $signed(p64)) || ($signed(gpu_avg) > $signed(p64)) ||
                   (($signed(ready) > $signed(t)) && ($signed(ready) < $signed(t_plus_p)));
        opa     <= ready - t;
      end
      S_PR_DIV2_WAIT: begin
        if (div_done) begin
          opa <= div_quo + {63'd0, (div_rem != 30'd0)};
        end
      end
      S_PR_MUL2_WAIT: begin
        if (mul_done) begin
          t <= t + mul_prod;
        end
      end
      S_PR_FIN: begin
        res_pred <= 1'b1;
        res_id   <= frame_counter;
        res_wake <= limited ? tm64[62:0] : wake_calc[62:0];
        res_tgt  <= t[61:0];
        res_per  <= period;
      end
      S_MK_RD: begin
        res_match <= match;
        sc        <= ($signed(dc) > $signed(lim64)) ? lim64 : dc;
        sg        <= ($signed(dg) > $signed(lim64)) ? lim64 : dg;
        which     <= 1'b0;
      end
      S_EW_SETUP: begin
        zero_r  <= (ew_a == 64'd0);
        neg_r   <= ew_d[63];
        lowprod <= {47'd0, lp[32:16]};
        opa     <= {16'd0, ew_mag[63:16]};
        opb     <= {13'd0, gain_eff};
      end
      S_EW_MUL_WAIT: begin
        if (mul_done) begin
          ew_prod <= mul_prod + lowprod;
        end
      end
      S_EW_UPD: begin
        which <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      is_prediction  <= res_pred;
      new_frame_id   <= res_id;
      wake_time      <= res_wake;
      target_display <= res_tgt;
      display_period <= res_per;
      app_time       <= app_calc;
      matched        <= res_match;
    end
  end

endmodule

// ----- hw/rtl/fdtp_checker.sv -----
// fdtp_checker: port-level assertions for the frame display time pacer
// depends on fdtp_pkg; bound to frame_display_time_pacer_top
`timescale 1ns / 1ps
module fdtp_checker import fdtp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_prediction,
  input logic [31:0] new_frame_id,
  input logic [62:0] wake_time,
  input logic        matched
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transaction completed");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a transaction is in work");

  // non-prediction results carry no frame id or wake time
  a_mark_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_prediction |-> new_frame_id == 32'd0 && wake_time == 63'd0)
    else $error("prediction fields set on a non-prediction result");

  // predictions never report a ring match
  a_pred_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_prediction |-> !matched)
    else $error("prediction result reports a match");

endmodule

bind frame_display_time_pacer_top fdtp_checker u_fdtp_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .is_prediction(is_prediction),
  .new_frame_id(new_frame_id), .wake_time(wake_time), .matched(matched)
);

// ----- dv/frame_display_time_pacer_top_tb.sv -----
// frame_display_time_pacer_top_tb: self-checking bench for the frame pacer
// depends on fdtp_pkg and frame_display_time_pacer_top, and through it on fdtp_div, fdtp_mul and fdtp_ring
`timescale 1ns / 1ps
module frame_display_time_pacer_top_tb;
  import fdtp_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic [31:0]        mark_id;
    logic [61:0]        time_ns;
    logic [61:0]        comp_display_time;
    logic [29:0]        comp_period;
    logic signed [31:0] comp_extra;
  } event_t;

  typedef struct packed {
    logic        is_prediction;
    logic [31:0] new_frame_id;
    logic [62:0] wake_time;
    logic [61:0] target_display;
    logic [29:0] display_period;
    logic [31:0] app_time;
    logic        matched;
  } pace_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] op = '0;
  logic [31:0] mark_id = '0;
  logic [61:0] time_ns = '0;
  logic [61:0] comp_display_time = '0;
  logic [29:0] comp_period = '0;
  logic signed [31:0] comp_extra = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_prediction;
  logic [31:0] new_frame_id;
  logic signed [62:0] wake_time;
  logic [61:0] target_display;
  logic [29:0] display_period;
  logic [31:0] app_time;
  logic matched;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  frame_display_time_pacer_top DUT (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [63:0] mrg, gain;
  logic [63:0] frame_cnt, last_disp, comp_disp, period, comp_t, cpu_avg, gpu_avg;
  logic [63:0] ring_tag [RING_DEPTH];
  logic [63:0] ring_wake [RING_DEPTH];
  logic [63:0] ring_del [RING_DEPTH];

  event_t pending_events[$];
  pace_t  expected_results[$];
  int errors = 0, mismatches = 0, checked = 0, predicts = 0, gpu_updates = 0;
  bit quiet = 1'b0;
  bit stim_done = 1'b0;
  longint unsigned cycles = 0;

  function automatic logic [63:0] cur_period();
    logic [63:0] p;
    p = period & 64'h3FFF_FFFF_FFFF_FFFF;
    return (p == 0) ? 64'd1 : p;
  endfunction

  // averaging step towards a sample, truncating towards zero
  function automatic logic [63:0] smooth(logic [63:0] a, logic signed [63:0] s);
    logic signed [63:0] d;
    logic [63:0] g, mag, prod;
    g = (gain > 64'd65536) ? 64'd65536 : gain;
    if (a == 0) return s;
    d = s - a;
    mag = (d < 0) ? -d : d;
    prod = (mag >> 16) * g + (((mag & 64'hFFFF) * g) >> 16);
    return (d < 0) ? a - prod : a + prod;
  endfunction

  function automatic void pacer_reset();
    mrg = 1500000; gain = 6554;
    frame_cnt = 0; last_disp = 0; comp_disp = 0; period = 10000000;
    comp_t = 0; cpu_avg = 0; gpu_avg = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_tag[i] = 0; ring_wake[i] = 0; ring_del[i] = 0;
    end
  endfunction

  // computes the result of one event and advances the predictor
  function automatic pace_t pace_event(event_t e);
    pace_t r;
    logic [63:0] p, t, sum, tm, diff, k, wv;
    logic signed [63:0] ready, q, c, g, app, lim, sc, sg;
    bit limited;
    int idx;
    r = '0;
    tm = {2'b0, e.time_ns};
    idx = int'(e.mark_id[IDX_W-1:0]);
    if (e.op == OP_PREDICT) begin
      p = cur_period();
      frame_cnt = (frame_cnt + 1) & 64'hFFFF_FFFF;
      sum = cpu_avg + gpu_avg + comp_t;
      ready = tm + sum;
      t = last_disp + p;
      q = $signed(p / 2 + t - comp_disp) / $signed(p);
      t = comp_disp + p * q;
      limited = $signed(cpu_avg) > $signed(p) || $signed(gpu_avg) > $signed(p) ||
                (ready > $signed(t) && ready < $signed(t + p));
      if ($signed(t) < ready) begin
        diff = ready - t;
        k = diff / p + ((diff % p) != 0);
        t = t + k * p;
      end
      wv = limited ? tm : t - (sum + mrg);
      r.wake_time = wv[62:0];
      last_disp = t;
      idx = int'(frame_cnt[IDX_W-1:0]);
      ring_tag[idx] = frame_cnt; ring_wake[idx] = 0; ring_del[idx] = 0;
      r.is_prediction = 1'b1;
      r.new_frame_id = frame_cnt[31:0];
      r.target_display = t[61:0];
      r.display_period = p[29:0];
      predicts++;
    end else if (e.op >= OP_WOKE && e.op <= OP_GPU_DONE) begin
      if (ring_tag[idx] == {32'b0, e.mark_id}) begin
        r.matched = 1'b1;
        if (e.op == OP_WOKE) ring_wake[idx] = tm;
        else if (e.op == OP_DELIVERED || e.op == OP_DISCARDED) ring_del[idx] = tm;
        else if (e.op == OP_GPU_DONE && ring_wake[idx] != 0 && ring_del[idx] != 0) begin
          lim = 3 * cur_period();
          sc = ring_del[idx] - ring_wake[idx];
          sg = tm - ring_del[idx];
          if (sc > lim) sc = lim;
          if (sg > lim) sg = lim;
          cpu_avg = smooth(cpu_avg, sc);
          gpu_avg = smooth(gpu_avg, sg);
          gpu_updates++;
        end
      end
    end else if (e.op == OP_INFO) begin
      comp_disp = {2'b0, e.comp_display_time};
      period = (e.comp_period == 0) ? 64'd1 : {34'b0, e.comp_period};
      comp_t = e.comp_extra[31] ? 64'd0 : {32'b0, e.comp_extra};
    end
    c = cpu_avg; g = gpu_avg;
    app = (c > g) ? c : g;
    if (app < 0) app = 0;
    if (app > 64'hFFFF_FFFF) app = 64'hFFFF_FFFF;
    r.app_time = app[31:0];
    return r;
  endfunction

  // accept flag seen at the last rising edge
  logic in_ready_s = 1'b0;
  always @(posedge clk) in_ready_s <= in_valid & in_ready;

  // input driver: bursts of idle, payload held until accepted
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!(in_valid && !in_ready_s)) begin
        if (in_valid && !quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          event_t e;
          e = pending_events.pop_front();
          in_valid <= 1'b1;
          op <= e.op; mark_id <= e.mark_id; time_ns <= e.time_ns;
          comp_display_time <= e.comp_display_time;
          comp_period <= e.comp_period; comp_extra <= e.comp_extra;
          expected_results.push_back(pace_event(e));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall: bursts of low ready
  int out_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_gap = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && out_ready) begin
      pace_t x, a;
      a = '{is_prediction, new_frame_id, wake_time, target_display, display_period,
            app_time, matched};
      if (expected_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        x = expected_results.pop_front();
        checked++;
        if (x !== a) begin
          errors++;
          if (mismatches++ < 10) begin
            $display("result %0d: expected pred=%0d id=%0d wake=%0d tgt=%0d per=%0d app=%0d m=%0d",
                     checked, x.is_prediction, x.new_frame_id, $signed(x.wake_time),
                     x.target_display, x.display_period, x.app_time, x.matched);
            $display("  got pred=%0d id=%0d wake=%0d tgt=%0d per=%0d app=%0d m=%0d",
                     a.is_prediction, a.new_frame_id, $signed(a.wake_time),
                     a.target_display, a.display_period, a.app_time, a.matched);
          end
        end
      end
    end
  end

  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_MARGIN) mrg = {32'd0, val & 32'h7FFFFF};
    else gain = {32'd0, val & 32'h1FFFF};
  endtask

  task automatic wait_idle();
    while (pending_events.size() > 0 || expected_results.size() > 0 || in_valid)
      @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic event_t mk(logic [2:0] o, logic [31:0] id, logic [61:0] tm);
    event_t e;
    e.op = o; e.mark_id = id; e.time_ns = tm;
    e.comp_display_time = 62'({$urandom, $urandom});
    e.comp_period = 30'($urandom);
    e.comp_extra = $urandom;
    return e;
  endfunction

  function automatic event_t mk_info(logic [61:0] disp, logic [29:0] per, logic [31:0] ext);
    event_t e;
    e = mk(OP_INFO, $urandom, 62'({$urandom, $urandom}));
    e.comp_display_time = disp; e.comp_period = per; e.comp_extra = ext;
    return e;
  endfunction

  // one plausible frame: optional info, predict, marks with rising times, gpu done
  task automatic push_frame(ref logic [61:0] clock_ns);
    logic [29:0] per;
    logic [31:0] id;
    per = 30'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000)
                                           : $urandom_range(5000000, 20000000));
    if ($urandom_range(0, 2) == 0)
      pending_events.push_back(mk_info(clock_ns + $urandom_range(0, 30000000), per,
                                       $urandom_range(0, 3) == 0 ? $urandom
                                                                 : $urandom_range(0, 3000000)));
    pending_events.push_back(mk(OP_PREDICT, $urandom, clock_ns));
    id = 32'(frame_cnt + 64'(pending_events.size()));
    clock_ns += $urandom_range(1, 4000000);
    pending_events.push_back(mk(OP_WOKE, id, clock_ns));
    clock_ns += $urandom_range(1, 4000000);
    pending_events.push_back(mk(OP_BEGIN, id, clock_ns));
    clock_ns += $urandom_range(1, 8000000);
    pending_events.push_back(mk($urandom_range(0, 3) == 0 ? OP_DISCARDED : OP_DELIVERED,
                                id, clock_ns));
    clock_ns += $urandom_range(1, 8000000);
    pending_events.push_back(mk(OP_GPU_DONE, id, clock_ns));
  endtask

  initial begin
    logic [61:0] clock_ns;
    int n;
    pacer_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, each op, frame id zero after reset, zero period, odd op
    pending_events.push_back(mk(OP_WOKE, 0, 62'd5));
    pending_events.push_back(mk(OP_BEGIN, 32'hFFFF_FFFF, '1));
    pending_events.push_back(mk(3'd7, $urandom, '1));
    pending_events.push_back(mk_info('1, 30'd0, 32'h8000_0000));
    pending_events.push_back(mk(OP_PREDICT, 0, 62'd0));
    pending_events.push_back(mk_info(62'd0, 30'd1000000000, 32'h7FFF_FFFF));
    pending_events.push_back(mk(OP_PREDICT, 0, '1));
    pending_events.push_back(mk_info(62'd100, 30'd16666667, 32'd1000000));
    pending_events.push_back(mk(OP_PREDICT, 0, 62'd1000));
    pending_events.push_back(mk(OP_WOKE, 3, 62'd2000000));
    pending_events.push_back(mk(OP_DELIVERED, 3, 62'd9000000));
    pending_events.push_back(mk(OP_GPU_DONE, 3, 62'd12000000));
    pending_events.push_back(mk(OP_PREDICT, 0, 62'd13000000));
    pending_events.push_back(mk(OP_WOKE, 4, 62'd14000000));
    pending_events.push_back(mk(OP_DISCARDED, 4, 62'd900000000));
    pending_events.push_back(mk(OP_GPU_DONE, 4, 62'd800000000));
    pending_events.push_back(mk(OP_GPU_DONE, 20, 62'd1));
    pending_events.push_back(mk(OP_PREDICT, 0, 62'd100000000));
    wait_idle();

    // random phases under several register settings, extremes included
    clock_ns = 62'd1000000;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(REG_MARGIN, 500000); reg_write(REG_GAIN, 0); end
        1: begin reg_write(REG_MARGIN, 5000000); reg_write(REG_GAIN, 65536); end
        2: begin reg_write(REG_MARGIN, 32'h7FFFFF); reg_write(REG_GAIN, 32'h1FFFF); end
        3: begin reg_write(REG_MARGIN, 0); reg_write(REG_GAIN, 1); end
        default: begin
          reg_write(REG_MARGIN, $urandom_range(500000, 5000000));
          reg_write(REG_GAIN, $urandom_range(0, 65536));
        end
      endcase
      if (ph == 5) quiet = 1'b1;
      n = 0;
      while (n < 240) begin
        if ($urandom_range(0, 4) == 0) begin
          event_t e;
          e = mk(3'($urandom_range(0, 7)),
                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40),
                 62'({$urandom, $urandom}));
          if (e.op == OP_PREDICT && $urandom_range(0, 1)) e.time_ns = clock_ns;
          pending_events.push_back(e);
          n++;
        end else begin
          push_frame(clock_ns);
          n += 5;
        end
      end
      wait_idle();
    end
    stim_done = 1'b1;
  end

  // end of run and timeout
  always @(posedge clk) begin
    if (stim_done) begin
      $display("%0d results checked: %0d predictions, %0d average updates, %0d errors",
               checked, predicts, gpu_updates, errors);
      if (errors == 0) begin
        $display("frame_display_time_pacer_top: match");
      end else begin
        $display("frame_display_time_pacer_top: mismatch");
      end
      $finish;
    end else if (cycles > 3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("frame_display_time_pacer_top: mismatch");
      $finish;
    end
  end

endmodule
